>>> rtl/beam_line_extrapolate_running_avg_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the beam line extrapolation block
// Short forms for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BEAM_LINE_EXTRAPOLATE_RUNNING_AVG_ASSERT_SVH
`define BEAM_LINE_EXTRAPOLATE_RUNNING_AVG_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define BLERA_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BLERA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/blera_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blera_pkg
// Shared types and constants of the beam line extrapolation block.
// ----------------------------------------------------------------------------
package blera_pkg;

   localparam int COORD_W = 32;            // Q16.16 coordinate
   localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
   localparam int SATI_W  = COORD_W + 2;   // input of the saturating clamp
   localparam int PROD_W  = 2 * COORD_W;   // |bz| * |d| stays below 2^63
   localparam int DEPTH_W = 5;             // window depth register
   localparam int LANES   = 3;             // x, y, z
   localparam int VALS    = 2 * LANES;     // pos x/y/z then dir x/y/z

   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic      command;
      coord_type first_x;
      coord_type first_y;
      coord_type first_z;
      coord_type second_x;
      coord_type second_y;
      coord_type second_z;
   } req_type;

   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
      logic      flat_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_POS,
      ST_RING,
      ST_UPD,
      ST_MEAN,
      ST_MEANW,
      ST_DONE
   } state_type;

   // sequencer strobes toward the datapath
   typedef struct packed {
      logic req_stall;
      logic mul_start;
      logic div_start;
      logic mean_start;
      logic res_clear;
      logic res_from_pos;
      logic res_from_mean;
      logic win_update;
      logic rsp_load;
   } ctl_type;

   // clamp a value two bits wider than a coordinate
   function automatic coord_type sat_coord(input logic [SATI_W-1:0] v);
      logic [2:0] top;
      top = v[SATI_W-1:COORD_W-1];
      if (top == 3'b000 || top == 3'b111) begin
         return v[COORD_W-1:0];
      end else if (v[SATI_W-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

endpackage

>>> rtl/blera_sermul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blera_sermul
// Serial shift-add multiplier: one multiplier bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module blera_sermul #(
   parameter int A_W = 32,
   parameter int B_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   mcand,
   input  logic [B_W-1:0]   mplier,
   output logic             done,
   output logic [A_W+B_W-1:0] product
);
   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W+B_W-1:0] prod_ff, prod_in;
   logic [A_W-1:0]     mcand_ff, mcand_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [A_W:0]       upper;

   // low bit of the shifting multiplier gates the add into the upper half
   always_comb begin
      upper    = {1'b0, prod_ff[A_W+B_W-1:B_W]}
               + (prod_ff[0] ? {1'b0, mcand_ff} : {(A_W+1){1'b0}});
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         prod_in  = {{A_W{1'b0}}, mplier};
         mcand_in = mcand;
         cnt_in   = CNT_W'(B_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {upper, prod_ff[B_W-1:1]};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

>>> rtl/blera_serdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blera_serdiv
// Serial restoring divider: one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module blera_serdiv #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   // dividend shifts out at the top while quotient bits shift in below
   always_comb begin
      shifted = {rem_ff, quot_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> rtl/beam_line_extrapolate_running_avg.sv
`timescale 1ns / 1ps
// Per-event time is set by the 33-step serial multiplier and the 64-step
//   serial divider, and with a window also by the serial mean divider
//   (SUM_W steps); flat events skip the multiply and divide.
// Throughput: one item at a time; the next item enters once the result is in the
//   output register. Clear commands are taken in the idle state and leave it idle.
// Reset: synchronous, clears the window, depth register and handshakes.
// ----------------------------------------------------------------------------
// beam_line_extrapolate_running_avg
// Extrapolates a two-point beam line to the z = 0 plane; with a depth of two
// or more, averages positions and directions over a ring of recent events.
// ----------------------------------------------------------------------------
module beam_line_extrapolate_running_avg #(
   parameter int WINDOW_MAX = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  blera_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output blera_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [blera_pkg::DEPTH_W-1:0]  csr_data
);
   import blera_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = COORD_W + IDX_W + 1;

   typedef logic [VALS-1:0][COORD_W-1:0] entry_type;

   state_type               state_ff, state_in;
   ctl_type                 ctl;
   req_type                 req_ff, req_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DEPTH_W-1:0]      depth_ff, depth_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic                    full_ff, full_in;
   logic signed [SUM_W-1:0] sums_ff [VALS];
   logic signed [SUM_W-1:0] sums_in [VALS];
   coord_type               res_ff [VALS];
   coord_type               res_in [VALS];
   logic                    flat_ff, flat_in;

   entry_type               ring_mem [WINDOW_MAX];
   entry_type               ring_rd_ff;
   entry_type               ring_wdata;

   logic                    accept;
   logic                    csr_write;
   logic                    win_clear;
   logic                    rsp_free;
   logic [CNT_W-1:0]        eff_depth;
   logic [CNT_W-1:0]        count;
   logic [CNT_W-1:0]        slot_next;
   logic                    windowed;

   coord_type               a_pt [LANES];
   coord_type               b_pt [LANES];
   logic signed [DIFF_W-1:0] draw [LANES];
   logic [DIFF_W-1:0]       draw_mag [LANES];
   logic                    neg [LANES];
   logic signed [DIFF_W-1:0] den;
   logic [DIFF_W-1:0]       den_mag;
   logic [COORD_W-1:0]      bz_mag;
   logic                    flat;

   logic [LANES-1:0]        mul_done;
   logic [COORD_W+DIFF_W-1:0] mul_prod [LANES];
   logic [LANES-1:0]        div_done;
   logic [PROD_W-1:0]       div_quot [LANES];
   logic [VALS-1:0]         mean_done;
   logic [SUM_W-1:0]        mean_quot [VALS];
   logic [SUM_W-1:0]        sum_mag [VALS];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;
   assign accept    = req_valid && !req_stall;
   assign win_clear = csr_write || (accept && req_data.command == CMD_CLEAR);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // effective depth, clipped to the ring size
   always_comb begin
      if (32'(depth_ff) > 32'(WINDOW_MAX)) begin
         eff_depth = CNT_W'(WINDOW_MAX);
      end else begin
         eff_depth = CNT_W'(depth_ff);
      end
      windowed  = eff_depth >= CNT_W'(2);
      count     = full_ff ? eff_depth : CNT_W'(slot_ff);
      slot_next = CNT_W'(slot_ff) + CNT_W'(1);
   end

   // line geometry from the held item
   always_comb begin
      a_pt[0] = req_ff.first_x;
      a_pt[1] = req_ff.first_y;
      a_pt[2] = req_ff.first_z;
      b_pt[0] = req_ff.second_x;
      b_pt[1] = req_ff.second_y;
      b_pt[2] = req_ff.second_z;
      den     = {a_pt[2][COORD_W-1], a_pt[2]} - {b_pt[2][COORD_W-1], b_pt[2]};
      den_mag = den[DIFF_W-1] ? (~den + 1'b1) : den;
      bz_mag  = b_pt[2][COORD_W-1] ? (~b_pt[2] + 1'b1) : b_pt[2];
      flat    = den == '0;
      for (int k = 0; k < LANES; k++) begin
         draw[k]     = {b_pt[k][COORD_W-1], b_pt[k]} - {a_pt[k][COORD_W-1], a_pt[k]};
         draw_mag[k] = draw[k][DIFF_W-1] ? (~draw[k] + 1'b1) : draw[k];
         neg[k]      = b_pt[2][COORD_W-1] ^ draw[k][DIFF_W-1] ^ den[DIFF_W-1];
      end
   end

   // per-lane serial multiply and divide: bz * d / den
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      blera_sermul #(
         .A_W (COORD_W),
         .B_W (DIFF_W)
      ) u_mul (
         .clock   (clock),
         .reset   (reset),
         .start   (ctl.mul_start),
         .mcand   (bz_mag),
         .mplier  (draw_mag[k]),
         .done    (mul_done[k]),
         .product (mul_prod[k])
      );

      blera_serdiv #(
         .NUM_W (PROD_W),
         .DEN_W (DIFF_W)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (ctl.div_start),
         .dividend (mul_prod[k][PROD_W-1:0]),
         .divisor  (den_mag),
         .done     (div_done[k]),
         .quotient (div_quot[k])
      );
   end

   // window mean: sum / count on each value
   for (genvar j = 0; j < VALS; j++) begin : g_mean
      assign sum_mag[j] = sums_ff[j][SUM_W-1] ? (~sums_ff[j] + 1'b1) : sums_ff[j];

      blera_serdiv #(
         .NUM_W (SUM_W),
         .DEN_W (CNT_W)
      ) u_mean (
         .clock    (clock),
         .reset    (reset),
         .start    (ctl.mean_start),
         .dividend (sum_mag[j]),
         .divisor  (count),
         .done     (mean_done[j]),
         .quotient (mean_quot[j])
      );
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.command == CMD_EVENT) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (!flat) begin
               state_in = ST_MUL;
            end else if (windowed && count != '0) begin
               state_in = ST_MEAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            if (mul_done[0]) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done[0]) state_in = ST_POS;
         end
         ST_POS: begin
            state_in = windowed ? ST_RING : ST_DONE;
         end
         ST_RING:  state_in = ST_UPD;
         ST_UPD:   state_in = ST_MEAN;
         ST_MEAN:  state_in = ST_MEANW;
         ST_MEANW: begin
            if (mean_done[0]) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: strobes
   always_comb begin
      ctl               = '0;
      ctl.req_stall     = state_ff != ST_IDLE;
      ctl.mul_start     = state_ff == ST_PREP && !flat;
      ctl.res_clear     = state_ff == ST_PREP && flat;
      ctl.div_start     = state_ff == ST_MUL && mul_done[0];
      ctl.res_from_pos  = state_ff == ST_POS;
      ctl.win_update    = state_ff == ST_UPD;
      ctl.mean_start    = state_ff == ST_MEAN;
      ctl.res_from_mean = state_ff == ST_MEANW && mean_done[0];
      ctl.rsp_load      = state_ff == ST_DONE && rsp_free;
   end

   assign req_stall = ctl.req_stall;

   // datapath next values
   always_comb begin
      logic [SATI_W-1:0] q_ext;
      logic [SATI_W-1:0] b_ext;
      logic [SATI_W-1:0] p_sum;
      logic [SUM_W-1:0]  q_signed;

      q_ext       = '0;
      b_ext       = '0;
      p_sum       = '0;
      q_signed    = '0;
      req_in      = req_ff;
      depth_in    = depth_ff;
      slot_in     = slot_ff;
      full_in     = full_ff;
      flat_in     = flat_ff;
      rsp_data_in = rsp_data_ff;
      for (int j = 0; j < VALS; j++) begin
         sums_in[j]    = sums_ff[j];
         res_in[j]     = res_ff[j];
         ring_wdata[j] = res_ff[j];
      end

      if (accept) req_in = req_data;
      if (csr_write) depth_in = csr_data;

      if (ctl.res_clear) begin
         for (int j = 0; j < VALS; j++) res_in[j] = '0;
      end
      if (state_ff == ST_PREP) flat_in = flat;

      // pos = b + bz*d/den, saturated; dir = b - a, saturated
      if (ctl.res_from_pos) begin
         for (int k = 0; k < LANES; k++) begin
            q_ext = {2'b00, div_quot[k][COORD_W-1:0]};
            b_ext = {{2{b_pt[k][COORD_W-1]}}, b_pt[k]};
            p_sum = neg[k] ? (b_ext - q_ext) : (b_ext + q_ext);
            if (|div_quot[k][PROD_W-1:COORD_W]) begin
               res_in[k] = neg[k] ? COORD_MIN : COORD_MAX;
            end else begin
               res_in[k] = sat_coord(p_sum);
            end
            res_in[LANES+k] = sat_coord({draw[k][DIFF_W-1], draw[k]});
         end
      end

      // ring update: drop the oldest entry once full, add the new one
      if (ctl.win_update) begin
         for (int j = 0; j < VALS; j++) begin
            sums_in[j] = sums_ff[j] + SUM_W'(res_ff[j])
                       - (full_ff ? SUM_W'($signed(ring_rd_ff[j])) : SUM_W'(0));
         end
         if (slot_next >= eff_depth) begin
            slot_in = '0;
            full_in = 1'b1;
         end else begin
            slot_in = slot_next[IDX_W-1:0];
         end
      end

      if (ctl.res_from_mean) begin
         for (int j = 0; j < VALS; j++) begin
            q_signed  = sums_ff[j][SUM_W-1] ? (~mean_quot[j] + 1'b1) : mean_quot[j];
            res_in[j] = q_signed[COORD_W-1:0];
         end
      end

      if (win_clear) begin
         slot_in = '0;
         full_in = 1'b0;
         for (int j = 0; j < VALS; j++) sums_in[j] = '0;
      end

      // output register
      if (ctl.rsp_load) begin
         rsp_data_in.pos_x      = res_ff[0];
         rsp_data_in.pos_y      = res_ff[1];
         rsp_data_in.pos_z      = res_ff[2];
         rsp_data_in.dir_x      = res_ff[3];
         rsp_data_in.dir_y      = res_ff[4];
         rsp_data_in.dir_z      = res_ff[5];
         rsp_data_in.flat_error = flat_ff;
      end

      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         slot_ff      <= '0;
         full_ff      <= 1'b0;
         for (int j = 0; j < VALS; j++) sums_ff[j] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
         slot_ff      <= slot_in;
         full_ff      <= full_in;
         for (int j = 0; j < VALS; j++) sums_ff[j] <= sums_in[j];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      flat_ff     <= flat_in;
      for (int j = 0; j < VALS; j++) res_ff[j] <= res_in[j];
   end

   // ring store, read before write at the current slot
   always_ff @(posedge clock) begin
      if (ctl.win_update) ring_mem[slot_ff] <= ring_wdata;
      ring_rd_ff <= ring_mem[slot_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "beam_line_extrapolate_running_avg_assert.svh"

   `BLERA_ASSERT_IMPLY(a_rsp_after_done, $rose(rsp_valid), $past(state_ff == ST_DONE), "result without finished item")
   `BLERA_ASSERT_IMPLY(a_slot_in_window, 1'b1, slot_ff == '0 || CNT_W'(slot_ff) < eff_depth, "write slot beyond window")
   `BLERA_ASSERT_IMPLY(a_lanes_aligned, mul_done[0] || div_done[0], mul_done[1] && mul_done[2] || div_done[1] && div_done[2], "serial lanes out of step")
   `BLERA_ASSERT_NEXT(a_event_busy, accept && req_data.command == CMD_EVENT, req_stall, "event accepted but block idle")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beam line extrapolation testbench
// Drives directed and random two-point events and clear commands through the
// block under several window depths and idling patterns. A local model of
// the extrapolation and the running mean predicts every result unless a
// directed row gives its own; each is compared field by field with the block's result.
// ----------------------------------------------------------------------------
module testbench;
   import blera_pkg::*;

   localparam int WIN_MAX    = 16;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_ITEMS = 290;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [DEPTH_W-1:0] csr_data;

   // typed expectation travels with the item that is offered
   bit      offer_typed;
   rsp_type offer_rsp;

   // local copy of the window state
   longint  pos_ring [WIN_MAX][3];
   longint  dir_ring [WIN_MAX][3];
   longint  pos_sum [3];
   longint  dir_sum [3];
   int      slot_next;
   bit      wrapped;
   int      depth_reg;

   rsp_type pending_q[$];
   int      errors;
   int      quiet_cycles;
   int      send_idle_pct;
   int      recv_idle_pct;
   stim_row_type rows[$];

   beam_line_extrapolate_running_avg #(.WINDOW_MAX(WIN_MAX)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic coord_type clamp(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(v);
   endfunction

   function automatic logic [127:0] magnitude(longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   // b + bz * d / den, truncated toward zero, saturated
   function automatic coord_type extrapolate(longint b, longint bz, longint d, longint den);
      logic [127:0] quot;
      bit           neg;
      longint       term;
      quot = (magnitude(bz) * magnitude(d)) / magnitude(den);
      neg  = ((bz < 0) != (d < 0)) != (den < 0);
      if (bz == 0 || d == 0) neg = 0;
      if (quot > (128'd1 << 60)) return neg ? COORD_MIN : COORD_MAX;
      term = longint'(quot[63:0]);
      return clamp(neg ? b - term : b + term);
   endfunction

   function automatic void clear_window();
      slot_next = 0;
      wrapped   = 0;
      for (int k = 0; k < 3; k++) begin
         pos_sum[k] = 0;
         dir_sum[k] = 0;
      end
   endfunction

   function automatic rsp_type window_mean(int depth, logic flat);
      rsp_type r;
      int      count;
      coord_type p [3];
      coord_type d [3];
      count = wrapped ? depth : slot_next;
      for (int k = 0; k < 3; k++) begin
         p[k] = (count != 0) ? clamp(pos_sum[k] / count) : '0;
         d[k] = (count != 0) ? clamp(dir_sum[k] / count) : '0;
      end
      r = '{p[0], p[1], p[2], d[0], d[1], d[2], flat};
      return r;
   endfunction

   // predicts the result of one item; returns 0 for a clear
   function automatic bit predict_track(req_type q, output rsp_type r);
      int      depth;
      longint  a [3];
      longint  b [3];
      longint  draw [3];
      coord_type p [3];
      coord_type d [3];
      longint  den;
      depth = (depth_reg > WIN_MAX) ? WIN_MAX : depth_reg;
      r = '0;
      if (q.command == CMD_CLEAR) begin
         clear_window();
         return 0;
      end
      a = '{longint'(q.first_x), longint'(q.first_y), longint'(q.first_z)};
      b = '{longint'(q.second_x), longint'(q.second_y), longint'(q.second_z)};
      den = a[2] - b[2];
      if (den == 0) begin
         if (depth >= 2) r = window_mean(depth, 1'b1);
         else r.flat_error = 1'b1;
         return 1;
      end
      for (int k = 0; k < 3; k++) begin
         draw[k] = b[k] - a[k];
         d[k] = clamp(draw[k]);
      end
      for (int k = 0; k < 3; k++) p[k] = extrapolate(b[k], b[2], draw[k], den);
      if (depth < 2) begin
         r = '{p[0], p[1], p[2], d[0], d[1], d[2], 1'b0};
         return 1;
      end
      for (int k = 0; k < 3; k++) begin
         if (wrapped) begin
            pos_sum[k] -= pos_ring[slot_next][k];
            dir_sum[k] -= dir_ring[slot_next][k];
         end
         pos_ring[slot_next][k] = p[k];
         dir_ring[slot_next][k] = d[k];
         pos_sum[k] += p[k];
         dir_sum[k] += d[k];
      end
      slot_next++;
      if (slot_next >= depth) begin
         slot_next = 0;
         wrapped   = 1;
      end
      r = window_mean(depth, 1'b0);
      return 1;
   endfunction

   task automatic check_coord(string name, coord_type want, coord_type got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // monitor: tracks accepted items, config writes and results
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (csr_valid && csr_ready) begin
            depth_reg = csr_data;
            clear_window();
         end
         if (req_valid && !req_stall) begin
            if (predict_track(req_data, want)) begin
               if (offer_typed) want = offer_rsp;
               pending_q.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_q.size() == 0) begin
               $error("result with no expectation waiting");
               errors++;
            end else begin
               want = pending_q.pop_front();
               check_coord("pos_x", want.pos_x, got.pos_x);
               check_coord("pos_y", want.pos_y, got.pos_y);
               check_coord("pos_z", want.pos_z, got.pos_z);
               check_coord("dir_x", want.dir_x, got.dir_x);
               check_coord("dir_y", want.dir_y, got.dir_y);
               check_coord("dir_z", want.dir_z, got.dir_z);
               if (want.flat_error !== got.flat_error) begin
                  $error("flat_error mismatch: expected %0b, actual %0b",
                         want.flat_error, got.flat_error);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return coord_type'($urandom_range(0, 2 ** 21) - 2 ** 20);
         6, 7: return coord_type'($urandom);
         8: return COORD_MIN;
         default: return COORD_MAX;
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type q;
      int      pick;
      pick = $urandom_range(0, 99);
      q.command  = (pick < 3) ? CMD_CLEAR : CMD_EVENT;
      q.first_x  = rand_coord();
      q.first_y  = rand_coord();
      q.first_z  = rand_coord();
      q.second_x = rand_coord();
      q.second_y = rand_coord();
      q.second_z = rand_coord();
      if (pick >= 3 && pick < 8) q.second_z = q.first_z;
      return q;
   endfunction

   // offers one item and waits for it to be taken, then maybe idles
   task automatic push_item(req_type q, bit typed, rsp_type r);
      req_valid   <= 1'b1;
      req_data    <= q;
      offer_typed <= typed;
      offer_rsp   <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // waits for the block to drain, then writes the depth register
   task automatic write_depth(logic [DEPTH_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk(logic cmd, coord_type ax, coord_type ay, coord_type az,
                                  coord_type bx, coord_type by, coord_type bz);
      req_type q;
      q = '{cmd, ax, ay, az, bx, by, bz};
      return q;
   endfunction

   initial begin
      int depths [7];
      depths = '{5'd0, 5'd2, 5'd16, 5'd1, 5'd31, 5'd7, 5'd3};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      rsp_stall     = 1'b0;
      offer_typed   = 1'b0;
      offer_rsp     = '0;
      errors        = 0;
      quiet_cycles  = 0;
      depth_reg     = 0;
      send_idle_pct = 28;
      recv_idle_pct = 47;
      for (int i = 0; i < WIN_MAX; i++) begin
         pos_ring[i] = '{0, 0, 0};
         dir_ring[i] = '{0, 0, 0};
      end
      clear_window();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows in pass-through after reset
      rows.push_back('{mk(CMD_EVENT, 0, 0, 32'sh10000, 0, 0, 32'sh20000), 1,
                       '{0, 0, 0, 0, 0, 32'sh10000, 1'b0}});
      rows.push_back('{mk(CMD_EVENT, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 0, 0, 1'b1}});
      rows.push_back('{mk(CMD_EVENT, COORD_MAX, COORD_MIN, COORD_MAX,
                          COORD_MAX, COORD_MIN, COORD_MAX), 1, '{0, 0, 0, 0, 0, 0, 1'b1}});
      rows.push_back('{mk(CMD_EVENT, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MAX), 0, '0});
      rows.push_back('{mk(CMD_EVENT, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MIN, COORD_MIN, COORD_MIN), 0, '0});
      rows.push_back('{mk(CMD_EVENT, 0, 0, COORD_MAX - 1, COORD_MAX, COORD_MIN, COORD_MAX),
                       0, '0});
      rows.push_back('{mk(CMD_EVENT, 0, 0, COORD_MIN + 1, COORD_MIN, COORD_MAX, COORD_MIN),
                       0, '0});
      rows.push_back('{mk(CMD_EVENT, -32'sd5, 32'sd7, -32'sd3, 32'sd9, -32'sd11, 32'sd4),
                       0, '0});
      rows.push_back('{mk(CMD_CLEAR, COORD_MAX, COORD_MIN, 0, 1, 2, 3), 0, '0});
      rows.push_back('{mk(CMD_EVENT, 32'sh30000, -32'sh20000, -32'sh10000,
                          32'sh50000, 32'sh10000, 32'sh10000), 0, '0});
      rows.push_back('{mk(CMD_EVENT, -32'sd1, -32'sd1, -32'sd1, 0, 0, 32'sd1), 0, '0});
      foreach (rows[i]) push_item(rows[i].req, rows[i].typed, rows[i].rsp);
      offer_typed <= 1'b0;

      // random phases across depths and idling patterns
      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 2) begin
            send_idle_pct = 47;
            recv_idle_pct = 28;
         end else if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_depth(DEPTH_W'(depths[ph]));
         // a flat event on an empty window reads back zeros
         push_item(mk(CMD_EVENT, 1, 2, 3, 4, 5, 3), 0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) push_item(rand_item(), 0, '0);
      end

      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/blera_pkg.sv
rtl/blera_sermul.sv
rtl/blera_serdiv.sv
rtl/beam_line_extrapolate_running_avg.sv
test/testbench.sv
